/* sv/pfnce_pkg.sv */
// ----------------------------------------------------------------------------
// pfnce_pkg: shared definitions for the prefix filter next character unit
// Operation and status codes, controller states, command and status
// structures, and the ASCII case folding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pfnce_pkg;

    localparam int MAX_LEN_DEF          = 128;
    localparam int MAX_ENTRIES_DEF      = 32;
    localparam int MAX_ENABLE_ITEMS     = 32;
    localparam int CHAR_W               = 8;
    localparam int OP_W                 = 3;
    localparam int STATUS_W             = 3;
    localparam int INDEX_W              = 5;
    localparam int TOTAL_W              = 6;
    localparam int NUM_CHARS            = 256;
    localparam int CHAR_CNT_W           = 9;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_PREFIX = 3'd1,
        OP_ENTRY  = 3'd2,
        OP_END    = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FOUND = 3'd0,
        ST_EXACT     = 3'd1,
        ST_UNIQUE    = 3'd2,
        ST_SEVERAL   = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUMMARY,
        S_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;          // apply the current request word
        logic load_summary;  // load the summary word into the output register
        logic load_enable;   // load the enable word for the current scan bit
        logic scan_step;     // skip a clear mask bit
    } pfnce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic can_load;      // output register is free or being emptied
        logic show;          // enable words follow the summary
        logic hit;           // mask bit at the scan position is set
        logic hit_last;      // that bit gives the final word of the query
    } pfnce_sts_t;

    function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]})
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/pfnce_ctrl.sv */
// ----------------------------------------------------------------------------
// pfnce_ctrl: controller state machine
// Accepts request words while idle and sequences the summary word and the
// mask scan of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module pfnce_ctrl
    import pfnce_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire logic [OP_W-1:0]  op,
    input  wire pfnce_sts_t       sts,
    output logic                  req_stall,
    output pfnce_cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && (op_t'(op) == OP_QUERY))
                begin
                    state_next = S_SUMMARY;
                end
            end
            S_SUMMARY:
            begin
                if (sts.can_load)
                begin
                    state_next = sts.show ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.hit && sts.can_load && sts.hit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        cmd       = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                cmd.take  = req_valid;
            end
            S_SUMMARY:
            begin
                cmd.load_summary = sts.can_load;
            end
            S_SCAN:
            begin
                cmd.load_enable = sts.hit && sts.can_load;
                cmd.scan_step   = !sts.hit;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/pfnce_dp.sv */
// ----------------------------------------------------------------------------
// pfnce_dp: datapath
// Prefix memory, entry matching, match bookkeeping, next character mask
// and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfnce_dp
    import pfnce_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pfnce_cmd_t           cmd,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [CHAR_W-1:0]    ch,
    output pfnce_sts_t                sts,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output logic                      kind,
    output logic [STATUS_W-1:0]       status,
    output logic [INDEX_W-1:0]        found_index,
    output logic [TOTAL_W-1:0]        match_total,
    output logic [CHAR_W-1:0]         enable_char,
    output logic                      last
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int EW = $clog2(MAX_ENTRIES + 1);

    logic [CHAR_W-1:0] prefix_mem [0:MAX_LEN-1];
    logic [CHAR_W-1:0] rd_data_reg;

    logic [LW-1:0]         prefix_len_reg,     prefix_len_next;
    logic [LW-1:0]         entry_pos_reg,      entry_pos_next;
    logic                  entry_matching_reg, entry_matching_next;
    logic [EW-1:0]         entry_count_reg,    entry_count_next;
    logic [EW-1:0]         match_count_reg,    match_count_next;
    logic                  exact_seen_reg,     exact_seen_next;
    logic [EW-1:0]         first_match_reg,    first_match_next;
    logic                  overflow_reg,       overflow_next;
    logic [NUM_CHARS-1:0]  mask_reg,           mask_next;
    logic [CHAR_CNT_W-1:0] chars_reg,          chars_next;
    logic [CHAR_W-1:0]     scan_idx_reg,       scan_idx_next;
    logic [TOTAL_W-1:0]    emit_cnt_reg,       emit_cnt_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  kind_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [INDEX_W-1:0]    found_index_reg;
    logic [TOTAL_W-1:0]    match_total_reg;
    logic [CHAR_W-1:0]     enable_char_reg;
    logic                  last_reg;

    logic                  pw_en;
    logic [AW-1:0]         pw_addr;
    logic [AW-1:0]         rd_addr;
    logic [CHAR_W-1:0]     up_ch;
    logic                  entries_full;

    status_t               sum_status;
    logic [INDEX_W-1:0]    sum_index;
    logic [TOTAL_W-1:0]    sum_total;
    logic                  show;
    logic [TOTAL_W-1:0]    item_limit;
    logic                  can_load;

    assign entries_full = (entry_count_reg >= EW'(MAX_ENTRIES));
    assign up_ch        = fold_upper(ch);
    assign pw_en        = cmd.take && (op_t'(op) == OP_PREFIX)
                          && (prefix_len_reg < LW'(MAX_LEN));
    assign pw_addr      = prefix_len_reg[AW-1:0];
    assign rd_addr      = entry_pos_next[AW-1:0];

    // Prefix memory. The read runs one word ahead at the next entry position,
    // with the write data forwarded when both hit the same location.
    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            prefix_mem[pw_addr] <= ch;
        end
        if (pw_en && (pw_addr == rd_addr))
        begin
            rd_data_reg <= ch;
        end
        else
        begin
            rd_data_reg <= prefix_mem[rd_addr];
        end
    end

    always_comb
    begin
        prefix_len_next     = prefix_len_reg;
        entry_pos_next      = entry_pos_reg;
        entry_matching_next = entry_matching_reg;
        entry_count_next    = entry_count_reg;
        match_count_next    = match_count_reg;
        exact_seen_next     = exact_seen_reg;
        first_match_next    = first_match_reg;
        overflow_next       = overflow_reg;
        mask_next           = mask_reg;
        chars_next          = chars_reg;
        if (cmd.take)
        begin
            case (op_t'(op))
                OP_CLEAR:
                begin
                    prefix_len_next     = '0;
                    entry_pos_next      = '0;
                    entry_matching_next = 1'b1;
                    entry_count_next    = '0;
                    match_count_next    = '0;
                    exact_seen_next     = 1'b0;
                    first_match_next    = '0;
                    overflow_next       = 1'b0;
                    mask_next           = '0;
                    chars_next          = '0;
                end
                OP_PREFIX:
                begin
                    if (prefix_len_reg < LW'(MAX_LEN))
                    begin
                        prefix_len_next = prefix_len_reg + 1'b1;
                    end
                end
                OP_ENTRY:
                begin
                    if (!entries_full && (entry_pos_reg < LW'(MAX_LEN)))
                    begin
                        if (entry_pos_reg < prefix_len_reg)
                        begin
                            if (fold_lower(ch) != fold_lower(rd_data_reg))
                            begin
                                entry_matching_next = 1'b0;
                            end
                        end
                        else if ((entry_pos_reg == prefix_len_reg) && entry_matching_reg)
                        begin
                            if (!mask_reg[up_ch])
                            begin
                                mask_next[up_ch] = 1'b1;
                                chars_next       = chars_reg + 1'b1;
                            end
                        end
                        entry_pos_next = entry_pos_reg + 1'b1;
                    end
                end
                OP_END:
                begin
                    if (entries_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        if (entry_matching_reg && (entry_pos_reg >= prefix_len_reg))
                        begin
                            if (match_count_reg == '0)
                            begin
                                first_match_next = entry_count_reg;
                            end
                            match_count_next = match_count_reg + 1'b1;
                            if (entry_pos_reg == prefix_len_reg)
                            begin
                                exact_seen_next = 1'b1;
                            end
                        end
                        entry_count_next = entry_count_reg + 1'b1;
                    end
                    entry_pos_next      = '0;
                    entry_matching_next = 1'b1;
                end
                default:
                begin
                    prefix_len_next = prefix_len_reg;
                end
            endcase
        end
    end

    // Query summary, computed from state that holds still during a query.
    always_comb
    begin
        sum_index = '0;
        sum_total = TOTAL_W'(match_count_reg);
        if (overflow_reg)
        begin
            sum_status = ST_OVERFLOW;
            sum_total  = '0;
        end
        else if (match_count_reg == '0)
        begin
            sum_status = ST_NOT_FOUND;
        end
        else if (exact_seen_reg)
        begin
            sum_status = ST_EXACT;
        end
        else if (match_count_reg == EW'(1))
        begin
            sum_status = ST_UNIQUE;
            sum_index  = INDEX_W'(first_match_reg);
        end
        else
        begin
            sum_status = ST_SEVERAL;
        end
    end

    assign show = !overflow_reg && (match_count_reg != '0) && (chars_reg != '0)
                  && !((match_count_reg == EW'(1)) && !exact_seen_reg);
    assign item_limit = (chars_reg > CHAR_CNT_W'(MAX_ENABLE_ITEMS))
                        ? TOTAL_W'(MAX_ENABLE_ITEMS) : TOTAL_W'(chars_reg);
    assign can_load = !rsp_valid_reg || !rsp_stall;

    assign sts.can_load = can_load;
    assign sts.show     = show;
    assign sts.hit      = mask_reg[scan_idx_reg];
    assign sts.hit_last = ((emit_cnt_reg + 1'b1) == item_limit);

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        emit_cnt_next = emit_cnt_reg;
        if (cmd.load_summary)
        begin
            scan_idx_next = '0;
            emit_cnt_next = '0;
        end
        else if (cmd.load_enable)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
            emit_cnt_next = emit_cnt_reg + 1'b1;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.load_summary || cmd.load_enable)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_len_reg     <= '0;
            entry_pos_reg      <= '0;
            entry_matching_reg <= 1'b1;
            entry_count_reg    <= '0;
            match_count_reg    <= '0;
            exact_seen_reg     <= 1'b0;
            first_match_reg    <= '0;
            overflow_reg       <= 1'b0;
            mask_reg           <= '0;
            chars_reg          <= '0;
            scan_idx_reg       <= '0;
            emit_cnt_reg       <= '0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            prefix_len_reg     <= prefix_len_next;
            entry_pos_reg      <= entry_pos_next;
            entry_matching_reg <= entry_matching_next;
            entry_count_reg    <= entry_count_next;
            match_count_reg    <= match_count_next;
            exact_seen_reg     <= exact_seen_next;
            first_match_reg    <= first_match_next;
            overflow_reg       <= overflow_next;
            mask_reg           <= mask_next;
            chars_reg          <= chars_next;
            scan_idx_reg       <= scan_idx_next;
            emit_cnt_reg       <= emit_cnt_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    // Response payload; loaded only together with a valid word.
    always_ff @(posedge clk)
    begin
        if (cmd.load_summary)
        begin
            kind_reg        <= 1'b0;
            status_reg      <= sum_status;
            found_index_reg <= sum_index;
            match_total_reg <= sum_total;
            enable_char_reg <= '0;
            last_reg        <= !show;
        end
        else if (cmd.load_enable)
        begin
            kind_reg        <= 1'b1;
            status_reg      <= sum_status;
            found_index_reg <= sum_index;
            match_total_reg <= sum_total;
            enable_char_reg <= scan_idx_reg;
            last_reg        <= sts.hit_last;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign found_index = found_index_reg;
    assign match_total = match_total_reg;
    assign enable_char = enable_char_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

/* sv/prefix_filter_next_char_enable_unit.sv */
// ----------------------------------------------------------------------------
// prefix_filter_next_char_enable_unit: virtual keyboard prefix filter
// Matches streamed dictionary entries against a stored prefix, ignoring
// ASCII case, and reports the match summary and the enabled next bytes.
// ----------------------------------------------------------------------------
// A user first clears the unit, loads the prefix one byte per request word,
// then streams each dictionary entry byte by byte and closes it with an
// end-of-entry word; while no query runs, a new one of these words can
// follow on the very next clock. Entries are not kept: the unit only
// counts matches, remembers whether one was exact and where the first one
// sat, and marks the upper-cased byte that follows the prefix in a 256-bit
// mask held in flip-flops, which reset and the clear word empty at once
// with no clearing pass. A query word blocks further request words until
// its last response word has been loaded: it gives one summary word from
// the summary state after acceptance, then walks the mask one bit per
// cycle from byte 0 upward, holding on a set bit while the response side
// stalls, and sends each set bit as an enable word, up to 32 of them. The
// response register lets the next request word be taken while the final
// response word of a query still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_filter_next_char_enable_unit
    import pfnce_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [CHAR_W-1:0]    ch,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output logic                      kind,
    output logic [STATUS_W-1:0]       status,
    output logic [INDEX_W-1:0]        found_index,
    output logic [TOTAL_W-1:0]        match_total,
    output logic [CHAR_W-1:0]         enable_char,
    output logic                      last
);

    pfnce_cmd_t cmd;
    pfnce_sts_t sts;

    // The controller owns the request handshake and the query sequence.
    pfnce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .op        (op),
        .sts       (sts),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    // The datapath holds all match state and the response register.
    pfnce_dp #(
        .MAX_LEN     (MAX_LEN),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .ch          (ch),
        .sts         (sts),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .kind        (kind),
        .status      (status),
        .found_index (found_index),
        .match_total (match_total),
        .enable_char (enable_char),
        .last        (last)
    );

`ifndef SYNTHESIS
    // An accepted query keeps the request side closed on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (op == OP_QUERY)) |=> req_stall)
    else $error("request taken during a query");

    // Enable words only follow a summary with at least one match.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && kind) |-> ((match_total != '0) && (status != ST_OVERFLOW)))
    else $error("enable word without matches");

    // Consecutive enable words of one query carry strictly rising bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && kind && $past(rsp_valid && !rsp_stall && kind))
        |-> (enable_char > $past(enable_char)))
    else $error("enable bytes out of order");
`endif

endmodule

`default_nettype wire
